[hdl/stmg_pkg.sv]
// Package for the slant TEC mapping core: fixed widths, reset values,
// CORDIC arctangent table, register indexes and pipeline sideband types.
// No dependencies.
package stmg_pkg;

    // Angle format: binary angle with 2^ANGLE_BITS per turn
    localparam int ANGLE_BITS = 16;
    localparam int ANG_SHIFT  = 32 - ANGLE_BITS;
    localparam int ANG_ZW     = ANGLE_BITS + 2;
    localparam logic signed [ANG_ZW-1:0] QUARTER_TURN = ANG_ZW'(2 ** (ANGLE_BITS - 2));

    // CORDIC rotator, Q2.30 x and y in 33-bit lanes, z as a 32-bit turn fraction
    localparam int ROT_W        = 33;
    localparam int CORDIC_STEPS = 30;
    localparam logic signed [ROT_W-1:0] CORDIC_START = 33'sd652032874;
    localparam logic [31:0] ARC_STEP [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

    // Datapath widths
    localparam int ACC_W   = 66;   // bracket accumulator
    localparam int SUM_W   = 34;   // bracket sum after the Q30 shift
    localparam int DEN_W   = 25;   // R + H
    localparam int NUM_W   = 55;   // R * |sin|
    localparam int X30_QW  = 31;   // quotient bits of the ratio divider
    localparam int ROOT_W  = 31;   // square root result bits
    localparam int FAC_QW  = 20;   // quotient bits of the factor divider
    localparam int PROD_W  = 55;   // sum * factor
    localparam logic [X30_QW-1:0] X30_ONE = X30_QW'(2 ** 30);
    // 2^46 / r fits 20 bits only for r > 2^26; 2^46 >> 20 is also the first remainder
    localparam logic [ROOT_W-1:0] FAC_LIM = ROOT_W'(2 ** 26);
    localparam logic [FAC_QW-1:0] MAP_MAX = 20'hFFFFF;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_EARTH_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA        = 2'd2;
    localparam logic [23:0] RST_EARTH_RADIUS = 24'd6371000;
    localparam logic [23:0] RST_LAYER_HEIGHT = 24'd506700;
    localparam logic [15:0] RST_ALPHA        = 16'd64107;

    // One CORDIC lane
    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ROT_W-1:0] z;
    } t_rot;

    // Sideband along the CORDIC row
    typedef struct packed {
        logic signed [31:0] dvtec;
        logic signed [31:0] grad_north;
        logic signed [31:0] grad_east;
        logic               flip_theta;
        logic               flip_az;
    } t_cside;

    // Sideband along the ratio divider
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    den_zero;
    } t_xside;

    // Sideband along the factor divider
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    fac_sat;
    } t_fside;

    // One result item
    typedef struct packed {
        logic              sat;
        logic [31:0]       stec;
        logic [FAC_QW-1:0] map;
    } t_result;

endpackage

[hdl/stmg_cordic_cell.sv]
// One rotation step of the twin CORDIC row (elevation and azimuth lanes).
// Depends on stmg_pkg.
module stmg_cordic_cell
    import stmg_pkg::*;
#(
    parameter int STEP   = 0,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_rot [1:0]        i_rot,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output t_rot [1:0]        o_rot,
    output logic [SIDE_W-1:0] o_side
);

    logic                    r_valid;
    t_rot [1:0]              r_rot;
    logic [SIDE_W-1:0]       r_side;
    t_rot [1:0]              n_rot;
    logic signed [ROT_W-1:0] arc;

    assign arc = $signed({1'b0, ARC_STEP[STEP]});

    // Rotate towards zero residual angle, shifts floor
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (!i_rot[l].z[ROT_W-1]) begin
                n_rot[l].x = i_rot[l].x - (i_rot[l].y >>> STEP);
                n_rot[l].y = i_rot[l].y + (i_rot[l].x >>> STEP);
                n_rot[l].z = i_rot[l].z - arc;
            end else begin
                n_rot[l].x = i_rot[l].x + (i_rot[l].y >>> STEP);
                n_rot[l].y = i_rot[l].y - (i_rot[l].x >>> STEP);
                n_rot[l].z = i_rot[l].z + arc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot  <= n_rot;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rot   = r_rot;
    assign o_side  = r_side;

endmodule

[hdl/stmg_div_cell.sv]
// One restoring step of an unsigned divider row: one quotient bit per cell.
// Depends on stmg_pkg.
module stmg_div_cell
    import stmg_pkg::*;
#(
    parameter int DW     = 25,
    parameter int QW     = 31,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DW-1:0]     i_rem,
    input  logic [DW-1:0]     i_den,
    input  logic [QW-1:0]     i_num,
    input  logic [QW-1:0]     i_quot,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [DW-1:0]     o_rem,
    output logic [DW-1:0]     o_den,
    output logic [QW-1:0]     o_num,
    output logic [QW-1:0]     o_quot,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_valid;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_den;
    logic [QW-1:0]     r_num;
    logic [QW-1:0]     r_quot;
    logic [SIDE_W-1:0] r_side;
    logic [DW:0]       trial;
    logic [DW:0]       diff;
    logic              fits;

    // Bring down the next numerator bit and try the subtraction
    assign trial = {i_rem, i_num[QW-1]};
    assign diff  = trial - {1'b0, i_den};
    assign fits  = trial >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= fits ? diff[DW-1:0] : trial[DW-1:0];
            r_den  <= i_den;
            r_num  <= {i_num[QW-2:0], 1'b0};
            r_quot <= {i_quot[QW-2:0], fits};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_num   = r_num;
    assign o_quot  = r_quot;
    assign o_side  = r_side;

endmodule

[hdl/stmg_sqrt_cell.sv]
// One digit step of a restoring integer square root row: one root bit per cell.
// Depends on stmg_pkg.
module stmg_sqrt_cell
    import stmg_pkg::*;
#(
    parameter int RW     = 31,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [RW+1:0]     i_rem,
    input  logic [RW-1:0]     i_root,
    input  logic [2*RW-1:0]   i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [RW+1:0]     o_rem,
    output logic [RW-1:0]     o_root,
    output logic [2*RW-1:0]   o_rad,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_valid;
    logic [RW+1:0]     r_rem;
    logic [RW-1:0]     r_root;
    logic [2*RW-1:0]   r_rad;
    logic [SIDE_W-1:0] r_side;
    logic [RW+3:0]     part;
    logic [RW+3:0]     test;
    logic [RW+3:0]     diff;
    logic              fits;

    // Bring down two radicand bits, test against 4*root + 1
    assign part = {i_rem, i_rad[2*RW-1 -: 2]};
    assign test = {2'b00, i_root, 2'b01};
    assign diff = part - test;
    assign fits = part >= test;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= fits ? diff[RW+1:0] : part[RW+1:0];
            r_root <= {i_root[RW-2:0], fits};
            r_rad  <= {i_rad[2*RW-3:0], 2'b00};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_rad   = r_rad;
    assign o_side  = r_side;

endmodule

[hdl/slant_tec_mapping_with_gradient_core.sv]
// Slant TEC mapping core: modified single-layer mapping factor and slant TEC change.
// Depends on stmg_pkg, stmg_cordic_cell, stmg_div_cell, stmg_sqrt_cell.
//
// Usage:
//   Slave stream takes one observation per transfer (elevation, azimuth, dvtec,
//   grad_north, grad_east). Master stream gives one result per observation
//   (map_factor, stec_delta in tdata; saturated flag in tuser), in order.
//   The configuration port writes R, H and alpha; write it only while no item
//   is in flight.
// Throughput: one item per cycle, sustained, as long as the receiver takes.
// Pipeline: the row of cells, in order: the input register, which loads at the
//   accepting edge, then 30 CORDIC cells, product stage, 31 ratio divider cells,
//   square stage, 31 square root cells, 20 factor divider cells, final product
//   stage and the output register.
// Reset: clears all valid bits and loads the default R, H and alpha.
// Stall: the result register is backed by a skid register; when that fills,
//   the whole row holds and o_s_axis_tready falls in the next cycle. No item is
//   lost or repeated.
module slant_tec_mapping_with_gradient_core
    import stmg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [15:0] elevation, [31:16] azimuth, [63:32] dvtec,
    // [95:64] grad_north, [127:96] grad_east
    input  logic [127:0]          i_s_axis_tdata,
    // master stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [19:0] map_factor, [51:20] stec_delta, [55:52] zero
    output logic [55:0]           o_m_axis_tdata,
    // [0] saturated
    output logic                  o_m_axis_tuser,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int CSIDE_W = $bits(t_cside);
    localparam int XSIDE_W = $bits(t_xside);
    localparam int FSIDE_W = $bits(t_fside);

    logic en;

    // ---------------- configuration registers ----------------
    logic [23:0] r_earth_radius;
    logic [23:0] r_layer_height;
    logic [15:0] r_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_earth_radius <= RST_EARTH_RADIUS;
            r_layer_height <= RST_LAYER_HEIGHT;
            r_alpha        <= RST_ALPHA;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EARTH_RADIUS: r_earth_radius <= i_cfg_wdata;
                CFG_LAYER_HEIGHT: r_layer_height <= i_cfg_wdata;
                CFG_ALPHA:        r_alpha        <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    logic               r_in_valid;
    logic [15:0]        r_in_elev;
    logic [15:0]        r_in_az;
    logic signed [31:0] r_in_dv;
    logic signed [31:0] r_in_gn;
    logic signed [31:0] r_in_ge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_elev <= i_s_axis_tdata[15:0];
            r_in_az   <= i_s_axis_tdata[31:16];
            r_in_dv   <= i_s_axis_tdata[63:32];
            r_in_gn   <= i_s_axis_tdata[95:64];
            r_in_ge   <= i_s_axis_tdata[127:96];
        end
    end

    assign o_s_axis_tready = en;

    // ---------------- angle preparation ----------------
    logic signed [ANG_ZW-1:0]    ang_z;
    logic signed [ANG_ZW+16:0]   theta_p;
    logic [63:0]                 theta_w;
    logic [31:0]                 theta32;
    logic [31:0]                 az32;
    logic                        flip_t;
    logic                        flip_a;
    logic [31:0]                 theta_f;
    logic [31:0]                 az_f;
    t_cside                      side_in;

    // theta = alpha * (quarter turn - elevation) as a 32-bit turn fraction
    assign ang_z   = QUARTER_TURN - ANG_ZW'($signed(r_in_elev[ANGLE_BITS-1:0]));
    assign theta_p = ang_z * $signed({1'b0, r_alpha});
    assign theta_w = 64'(theta_p) << ANG_SHIFT;
    assign theta32 = theta_w[47:16];
    assign az32    = 32'(r_in_az[ANGLE_BITS-1:0]) << ANG_SHIFT;

    // Second and third quadrants rotate by half a turn; azimuth negates afterwards, theta uses |sin|
    assign flip_t  = theta32[31] ^ theta32[30];
    assign flip_a  = az32[31] ^ az32[30];
    assign theta_f = theta32 ^ {flip_t, 31'b0};
    assign az_f    = az32 ^ {flip_a, 31'b0};

    assign side_in.dvtec      = r_in_dv;
    assign side_in.grad_north = r_in_gn;
    assign side_in.grad_east  = r_in_ge;
    assign side_in.flip_theta = flip_t;
    assign side_in.flip_az    = flip_a;

    // ---------------- CORDIC row ----------------
    logic               c_valid [CORDIC_STEPS+1];
    t_rot [1:0]         c_rot   [CORDIC_STEPS+1];
    logic [CSIDE_W-1:0] c_side  [CORDIC_STEPS+1];

    assign c_valid[0]  = r_in_valid;
    assign c_rot[0][0] = '{x: CORDIC_START, y: '0, z: ROT_W'($signed(theta_f))};
    assign c_rot[0][1] = '{x: CORDIC_START, y: '0, z: ROT_W'($signed(az_f))};
    assign c_side[0]   = side_in;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        stmg_cordic_cell #(
            .STEP   (g),
            .SIDE_W (CSIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c_valid[g]),
            .i_rot   (c_rot[g]),
            .i_side  (c_side[g]),
            .o_valid (c_valid[g+1]),
            .o_rot   (c_rot[g+1]),
            .o_side  (c_side[g+1])
        );
    end

    // ---------------- product stage ----------------
    t_cside                  cs;
    logic signed [ROT_W-1:0] s_th;
    logic [ROT_W-1:0]        s_abs;
    logic signed [ROT_W-1:0] c_az;
    logic signed [ROT_W-1:0] s_az;

    logic                    r_b_valid;
    logic signed [31:0]      r_b_dv;
    logic signed [64:0]      r_b_pc;
    logic signed [64:0]      r_b_ps;
    logic [NUM_W-1:0]        r_b_num;

    assign cs    = c_side[CORDIC_STEPS];
    assign s_th  = c_rot[CORDIC_STEPS][0].y;
    assign s_abs = s_th[ROT_W-1] ? -s_th : s_th;
    assign c_az  = cs.flip_az ? -c_rot[CORDIC_STEPS][1].x : c_rot[CORDIC_STEPS][1].x;
    assign s_az  = cs.flip_az ? -c_rot[CORDIC_STEPS][1].y : c_rot[CORDIC_STEPS][1].y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= c_valid[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_dv  <= cs.dvtec;
            r_b_pc  <= c_az * cs.grad_north;
            r_b_ps  <= s_az * cs.grad_east;
            r_b_num <= r_earth_radius * s_abs[30:0];
        end
    end

    // Bracket sum, floored back from Q30
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] acc_sh;
    logic [DEN_W-1:0]        den;
    t_xside                  xside_in;

    assign acc    = (ACC_W'(r_b_dv) <<< 30) + ACC_W'(r_b_pc) + ACC_W'(r_b_ps);
    assign acc_sh = acc >>> 30;
    assign den    = {1'b0, r_earth_radius} + {1'b0, r_layer_height};

    assign xside_in.sum      = acc_sh[SUM_W-1:0];
    assign xside_in.den_zero = (den == '0);

    // ---------------- ratio divider row: R*|sin| / (R+H) ----------------
    logic               x_valid [X30_QW+1];
    logic [DEN_W-1:0]   x_rem   [X30_QW+1];
    logic [DEN_W-1:0]   x_den   [X30_QW+1];
    logic [X30_QW-1:0]  x_num   [X30_QW+1];
    logic [X30_QW-1:0]  x_quot  [X30_QW+1];
    logic [XSIDE_W-1:0] x_side  [X30_QW+1];

    // The quotient stays below 2^31, so the high numerator bits are below R+H
    assign x_valid[0] = r_b_valid;
    assign x_rem[0]   = {1'b0, r_b_num[NUM_W-1:X30_QW]};
    assign x_den[0]   = den;
    assign x_num[0]   = r_b_num[X30_QW-1:0];
    assign x_quot[0]  = '0;
    assign x_side[0]  = xside_in;

    for (genvar g = 0; g < X30_QW; g++) begin : g_xdiv
        stmg_div_cell #(
            .DW     (DEN_W),
            .QW     (X30_QW),
            .SIDE_W (XSIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (x_valid[g]),
            .i_rem   (x_rem[g]),
            .i_den   (x_den[g]),
            .i_num   (x_num[g]),
            .i_quot  (x_quot[g]),
            .i_side  (x_side[g]),
            .o_valid (x_valid[g+1]),
            .o_rem   (x_rem[g+1]),
            .o_den   (x_den[g+1]),
            .o_num   (x_num[g+1]),
            .o_quot  (x_quot[g+1]),
            .o_side  (x_side[g+1])
        );
    end

    // ---------------- clamp and square stage ----------------
    t_xside              xs;
    logic [X30_QW-1:0]   x30;
    logic [2*X30_QW-1:0] x30_sq;

    logic                r_c_valid;
    logic [60:0]         r_c_sq;
    logic [SUM_W-1:0]    r_c_sum;

    assign xs     = x_side[X30_QW];
    assign x30    = xs.den_zero ? '0 :
                    (x_quot[X30_QW] > X30_ONE) ? X30_ONE : x_quot[X30_QW];
    assign x30_sq = x30 * x30;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= x_valid[X30_QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_sq  <= x30_sq[60:0];
            r_c_sum <= xs.sum;
        end
    end

    // ---------------- square root row: sqrt(2^60 - x^2) ----------------
    logic [60:0]        rad_v;
    logic               q_valid [ROOT_W+1];
    logic [ROOT_W+1:0]  q_rem   [ROOT_W+1];
    logic [ROOT_W-1:0]  q_root  [ROOT_W+1];
    logic [2*ROOT_W-1:0] q_rad  [ROOT_W+1];
    logic [SUM_W-1:0]   q_side  [ROOT_W+1];

    assign rad_v      = {1'b1, 60'b0} - r_c_sq;
    assign q_valid[0] = r_c_valid;
    assign q_rem[0]   = '0;
    assign q_root[0]  = '0;
    assign q_rad[0]   = {1'b0, rad_v};
    assign q_side[0]  = r_c_sum;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        stmg_sqrt_cell #(
            .RW     (ROOT_W),
            .SIDE_W (SUM_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (q_valid[g]),
            .i_rem   (q_rem[g]),
            .i_root  (q_root[g]),
            .i_rad   (q_rad[g]),
            .i_side  (q_side[g]),
            .o_valid (q_valid[g+1]),
            .o_rem   (q_rem[g+1]),
            .o_root  (q_root[g+1]),
            .o_rad   (q_rad[g+1]),
            .o_side  (q_side[g+1])
        );
    end

    // ---------------- factor divider row: 2^46 / r ----------------
    t_fside             fside_in;
    logic               f_valid [FAC_QW+1];
    logic [ROOT_W-1:0]  f_rem   [FAC_QW+1];
    logic [ROOT_W-1:0]  f_den   [FAC_QW+1];
    logic [FAC_QW-1:0]  f_num   [FAC_QW+1];
    logic [FAC_QW-1:0]  f_quot  [FAC_QW+1];
    logic [FSIDE_W-1:0] f_side  [FAC_QW+1];

    // A root of 2^26 or less (zero included) gives a factor out of range
    assign fside_in.sum     = q_side[ROOT_W];
    assign fside_in.fac_sat = (q_root[ROOT_W] <= FAC_LIM);

    assign f_valid[0] = q_valid[ROOT_W];
    assign f_rem[0]   = FAC_LIM;
    assign f_den[0]   = q_root[ROOT_W];
    assign f_num[0]   = '0;
    assign f_quot[0]  = '0;
    assign f_side[0]  = fside_in;

    for (genvar g = 0; g < FAC_QW; g++) begin : g_fdiv
        stmg_div_cell #(
            .DW     (ROOT_W),
            .QW     (FAC_QW),
            .SIDE_W (FSIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (f_valid[g]),
            .i_rem   (f_rem[g]),
            .i_den   (f_den[g]),
            .i_num   (f_num[g]),
            .i_quot  (f_quot[g]),
            .i_side  (f_side[g]),
            .o_valid (f_valid[g+1]),
            .o_rem   (f_rem[g+1]),
            .o_den   (f_den[g+1]),
            .o_num   (f_num[g+1]),
            .o_quot  (f_quot[g+1]),
            .o_side  (f_side[g+1])
        );
    end

    // ---------------- slant product stage ----------------
    t_fside               fs;
    logic [FAC_QW-1:0]    fac;

    logic                 r_d_valid;
    logic signed [PROD_W-1:0] r_d_prod;
    logic [FAC_QW-1:0]    r_d_fac;
    logic                 r_d_sat;

    assign fs  = f_side[FAC_QW];
    assign fac = fs.fac_sat ? MAP_MAX : f_quot[FAC_QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (en) begin
            r_d_valid <= f_valid[FAC_QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_prod <= fs.sum * $signed({1'b0, fac});
            r_d_fac  <= fac;
            r_d_sat  <= fs.fac_sat;
        end
    end

    // Floor back from Q16 and clip to 32 bits
    logic signed [PROD_W-17:0] slant;
    logic                      ovf;
    t_result                   p_res;

    assign slant = r_d_prod[PROD_W-1:16];
    assign ovf   = !((&slant[PROD_W-17:31]) || !(|slant[PROD_W-17:31]));

    assign p_res.map  = r_d_fac;
    assign p_res.stec = !ovf ? slant[31:0] :
                        slant[PROD_W-17] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign p_res.sat  = r_d_sat | ovf;

    // ---------------- output register with skid ----------------
    logic    r_out_valid;
    t_result r_out;
    logic    r_skd_valid;
    t_result r_skd;
    logic    take;

    assign en   = !r_skd_valid;
    assign take = r_out_valid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (en) begin
            if (r_d_valid) begin
                if (!r_out_valid || take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skd_valid <= 1'b1;
                end
            end else if (take) begin
                r_out_valid <= 1'b0;
            end
        end else if (take) begin
            r_skd_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_d_valid) begin
                if (!r_out_valid || take) begin
                    r_out <= p_res;
                end else begin
                    r_skd <= p_res;
                end
            end
        end else if (take) begin
            r_out <= r_skd;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0, r_out.stec, r_out.map};
    assign o_m_axis_tuser  = r_out.sat;

    // ---------------- assertions ----------------
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> r_out_valid)
        else $error("skid register holds a result while the output register is empty");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skd_valid && !i_m_axis_tready) |=> r_skd_valid)
        else $error("skid result dropped while the receiver stalls");

    a_row_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |=> $stable(r_d_valid) || !$past(r_skd_valid))
        else $error("pipeline moved while the skid register was full");

    a_sat_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.map != MAP_MAX && r_out.stec != 32'h7FFF_FFFF
         && r_out.stec != 32'h8000_0000) |-> !r_out.sat)
        else $error("saturated flag set without a clipped result");

endmodule
